### src/scdh_pkg.sv
// ----------------------------------------------------------------------------
// scdh_pkg
// Shared types and constants for the segment coverage depth histogram.
// ----------------------------------------------------------------------------
package scdh_pkg;

    localparam int unsigned InCoordW  = 40;
    localparam int unsigned DepthW    = 7;
    localparam int unsigned CountW    = 40;
    localparam int unsigned DeltaW    = 8;

    typedef struct packed {
        logic [InCoordW-1:0] seg_left;
        logic [InCoordW-1:0] seg_right;
        logic                final_segment;
    } t_in_item;

    typedef struct packed {
        logic [DepthW-1:0] depth;
        logic [CountW-1:0] point_count;
        logic              overflow;
        logic              last_result;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_LEFT,
        ST_INS_RIGHT,
        ST_SWEEP,
        ST_EMIT
    } t_state;

    // control broadcast from the controller to every cell
    typedef struct packed {
        logic insert;  // offer an event to the chain this cycle
        logic hit;     // some cell already holds the offered coordinate
        logic shift;   // sweep: move all entries one cell toward the head
        logic clear;   // drop every entry
    } t_cell_ctl;

endpackage

### src/scdh_cell.sv
// ----------------------------------------------------------------------------
// scdh_cell
// One slot of the sorted event chain. Insert compares the broadcast
// coordinate with its own and its lower neighbor's, then keeps, merges,
// or takes the new or neighbor's entry. Sweep shifts entries to the head.
// ----------------------------------------------------------------------------
module scdh_cell #(
    parameter int unsigned CW = 41
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  scdh_pkg::t_cell_ctl        i_ctl,
    input  logic [CW-1:0]              i_coord,
    input  logic signed [scdh_pkg::DeltaW-1:0] i_delta,
    input  logic                       i_prev_valid,
    input  logic                       i_prev_gt,
    input  logic [CW-1:0]              i_prev_coord,
    input  logic signed [scdh_pkg::DeltaW-1:0] i_prev_delta,
    input  logic                       i_next_valid,
    input  logic [CW-1:0]              i_next_coord,
    input  logic signed [scdh_pkg::DeltaW-1:0] i_next_delta,
    output logic                       o_valid,
    output logic                       o_gt,
    output logic                       o_eq,
    output logic [CW-1:0]              o_coord,
    output logic signed [scdh_pkg::DeltaW-1:0] o_delta
);

    logic                               r_valid;
    logic [CW-1:0]                      r_coord;
    logic signed [scdh_pkg::DeltaW-1:0] r_delta;
    logic                               w_eq;

    // o_gt: this entry sits above the new coordinate and must move up
    assign o_gt    = r_valid && (r_coord > i_coord);
    assign w_eq    = r_valid && (r_coord == i_coord);
    assign o_eq    = w_eq;
    assign o_valid = r_valid;
    assign o_coord = r_coord;
    assign o_delta = r_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_next_valid;
            r_coord <= i_next_coord;
            r_delta <= i_next_delta;
        end else if (i_ctl.insert) begin
            if (w_eq) begin
                r_delta <= r_delta + i_delta;
            end else if (!i_ctl.hit) begin
                if (o_gt) begin
                    if (i_prev_gt) begin
                        r_coord <= i_prev_coord;
                        r_delta <= i_prev_delta;
                    end else begin
                        r_coord <= i_coord;
                        r_delta <= i_delta;
                    end
                end else if (!r_valid && i_prev_valid && !i_prev_gt) begin
                    r_valid <= 1'b1;
                    r_coord <= i_coord;
                    r_delta <= i_delta;
                end else if (!r_valid && i_prev_gt) begin
                    r_valid <= 1'b1;
                    r_coord <= i_prev_coord;
                    r_delta <= i_prev_delta;
                end
            end
        end
    end

endmodule

### src/segment_coverage_depth_histogram_core.sv
// ----------------------------------------------------------------------------
// segment_coverage_depth_histogram_core
// Sorted-event sweep over closed segments, reporting points per depth.
// ----------------------------------------------------------------------------
// A segment item is inserted one endpoint at a time into a chain of
// 2*MAX_SEGMENTS event cells that compare in parallel and shift up. An
// item marked final_segment then sweeps the chain, for each event reading
// the depth bin, then adding the gap and shifting the cells toward the head,
// until it finds the chain empty, and emits one result per cycle for depths
// 1..n (at least one result). For a final item, busy stays high from accept
// through the last emit cycle and drops in the cycle in which the last
// result is strobed. Results cannot be stalled by the receiver.
module segment_coverage_depth_histogram_core #(
    parameter int unsigned MAX_SEGMENTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  scdh_pkg::t_in_item   i_item,
    output logic                 o_strobe,
    output scdh_pkg::t_out_item  o_item
);

    localparam int unsigned CW    = scdh_pkg::InCoordW + 1;
    localparam int unsigned NCELL = 2 * MAX_SEGMENTS;
    localparam int unsigned SW    = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned HW    = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned BW    = CW;
    localparam logic [scdh_pkg::CountW-1:0] CountMax = '1;

    scdh_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_left, r_right;
    logic             r_final;
    logic [SW-1:0]    r_nseg;
    logic             r_drop;
    logic [HW-1:0]    r_emit;
    logic signed [scdh_pkg::DeltaW-1:0] r_depth;
    logic [CW-1:0]    r_prev_coord;
    logic             r_have_prev;
    logic             r_phase;
    logic [BW-1:0]    r_hrd;
    logic             r_hrd_v;
    logic [MAX_SEGMENTS:0] r_hvalid;
    logic [BW-1:0]    r_hist [MAX_SEGMENTS+1];

    scdh_pkg::t_cell_ctl w_ctl;
    logic [CW-1:0]    w_coord;
    logic signed [scdh_pkg::DeltaW-1:0] w_delta;
    logic             w_valid [NCELL+1];
    logic             w_gt    [NCELL+1];
    logic [CW-1:0]    w_c     [NCELL+1];
    logic signed [scdh_pkg::DeltaW-1:0] w_d [NCELL+1];
    logic [NCELL-1:0] w_eq;
    logic [CW-1:0]    w_in_left, w_in_right;
    logic             w_take;
    logic [BW-1:0]    w_hsel;
    logic [scdh_pkg::CountW-1:0] w_cnt;
    logic             w_rng;
    logic [HW-1:0]    w_didx;
    logic             w_hrd_en;
    logic [HW-1:0]    w_hraddr;
    logic             w_hwr_en;
    logic [BW-1:0]    w_hwdata;

    assign w_in_left  = {1'b0, i_item.seg_left};
    assign w_in_right = {1'b0, i_item.seg_right};
    assign w_take     = start && !busy;
    assign busy       = (r_state != scdh_pkg::ST_IDLE);

    // chain boundaries: head has a valid lower neighbor that is never greater, tail an empty upper
    assign w_valid[0] = 1'b1;
    assign w_gt[0]    = 1'b0;
    assign w_c[0]     = '0;
    assign w_d[0]     = '0;

    assign w_coord = (r_state == scdh_pkg::ST_INS_LEFT) ? r_left : r_right + CW'(1);
    assign w_delta = (r_state == scdh_pkg::ST_INS_LEFT) ? 8'sd1 : -8'sd1;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        logic             nv;
        logic [CW-1:0]    nc;
        logic signed [scdh_pkg::DeltaW-1:0] nd;
        if (g == NCELL - 1) begin : g_tail
            assign nv = 1'b0;
            assign nc = '0;
            assign nd = '0;
        end else begin : g_mid
            assign nv = w_valid[g+2];
            assign nc = w_c[g+2];
            assign nd = w_d[g+2];
        end
        scdh_cell #(.CW(CW)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_coord     (w_coord),
            .i_delta     (w_delta),
            .i_prev_valid(w_valid[g]),
            .i_prev_gt   (w_gt[g]),
            .i_prev_coord(w_c[g]),
            .i_prev_delta(w_d[g]),
            .i_next_valid(nv),
            .i_next_coord(nc),
            .i_next_delta(nd),
            .o_valid     (w_valid[g+1]),
            .o_gt        (w_gt[g+1]),
            .o_eq        (w_eq[g]),
            .o_coord     (w_c[g+1]),
            .o_delta     (w_d[g+1])
        );
    end

    always_comb begin
        n_state   = r_state;
        w_ctl     = '0;
        w_ctl.hit = |w_eq;
        unique case (r_state)
            scdh_pkg::ST_IDLE: begin
                if (w_take) begin
                    n_state = scdh_pkg::ST_INS_LEFT;
                end
            end
            scdh_pkg::ST_INS_LEFT: begin
                if (r_left <= r_right && SW'(r_nseg) < SW'(MAX_SEGMENTS)) begin
                    w_ctl.insert = 1'b1;
                end
                n_state = scdh_pkg::ST_INS_RIGHT;
            end
            scdh_pkg::ST_INS_RIGHT: begin
                if (r_left <= r_right && SW'(r_nseg) < SW'(MAX_SEGMENTS)) begin
                    w_ctl.insert = 1'b1;
                end
                n_state = r_final ? scdh_pkg::ST_SWEEP : scdh_pkg::ST_IDLE;
            end
            scdh_pkg::ST_SWEEP: begin
                w_ctl.shift = r_phase;
                if (!r_phase && !w_valid[1]) begin
                    n_state = scdh_pkg::ST_EMIT;
                end
            end
            scdh_pkg::ST_EMIT: begin
                if (r_emit >= r_nseg) begin
                    w_ctl.clear = 1'b1;
                    n_state     = scdh_pkg::ST_IDLE;
                end
            end
            default: n_state = scdh_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scdh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_left  <= w_in_left;
            r_right <= w_in_right;
            r_final <= i_item.final_segment;
        end
    end

    // histogram bin access: one registered read and one write per cycle
    assign w_rng  = !r_depth[scdh_pkg::DeltaW-1] &&
                    (r_depth <= $signed(scdh_pkg::DeltaW'(MAX_SEGMENTS)));
    assign w_didx = HW'(r_depth);

    always_comb begin
        w_hrd_en = 1'b0;
        w_hraddr = w_didx;
        if (r_state == scdh_pkg::ST_SWEEP && !r_phase) begin
            if (w_valid[1]) begin
                w_hrd_en = w_rng;
            end else begin
                w_hrd_en = 1'b1;
                w_hraddr = HW'(1);
            end
        end else if (r_state == scdh_pkg::ST_EMIT && r_emit < r_nseg) begin
            w_hrd_en = 1'b1;
            w_hraddr = r_emit + HW'(1);
        end
    end

    assign w_hwr_en = (r_state == scdh_pkg::ST_SWEEP) && r_phase && w_valid[1] &&
                      r_have_prev && w_rng;
    assign w_hwdata = (r_hrd_v ? r_hrd : '0) + (w_c[1] - r_prev_coord);

    always_ff @(posedge i_clk) begin
        if (w_hwr_en) begin
            r_hist[w_didx] <= w_hwdata;
        end
        if (w_hrd_en) begin
            r_hrd <= r_hist[w_hraddr];
        end
    end

    // registered bin of the emit index; depth 1..n
    assign w_hsel = r_hrd_v ? r_hrd : '0;
    assign w_cnt  = (w_hsel > BW'(CountMax)) ? CountMax : w_hsel[scdh_pkg::CountW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nseg      <= '0;
            r_drop      <= 1'b0;
            r_emit      <= '0;
            r_depth     <= '0;
            r_have_prev <= 1'b0;
            r_phase     <= 1'b0;
            r_hrd_v     <= 1'b0;
            r_hvalid    <= '0;
            o_strobe    <= 1'b0;
        end else begin
            o_strobe <= (r_state == scdh_pkg::ST_EMIT);
            if (w_hrd_en) begin
                r_hrd_v <= r_hvalid[w_hraddr];
            end
            if (r_state == scdh_pkg::ST_INS_RIGHT && r_left <= r_right) begin
                if (SW'(r_nseg) < SW'(MAX_SEGMENTS)) begin
                    r_nseg <= r_nseg + SW'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (r_state == scdh_pkg::ST_SWEEP) begin
                r_phase <= !r_phase && w_valid[1];
                if (r_phase) begin
                    if (w_hwr_en) begin
                        r_hvalid[w_didx] <= 1'b1;
                    end
                    r_depth      <= r_depth + w_d[1];
                    r_prev_coord <= w_c[1];
                    r_have_prev  <= 1'b1;
                end else if (!w_valid[1]) begin
                    r_emit <= HW'(1);
                end
            end
            if (r_state == scdh_pkg::ST_EMIT) begin
                o_item.depth       <= scdh_pkg::DepthW'(r_emit);
                o_item.point_count <= (r_nseg == '0) ? '0 : w_cnt;
                o_item.overflow    <= r_drop;
                o_item.last_result <= (r_emit >= r_nseg);
                if (r_emit >= r_nseg) begin
                    r_nseg      <= '0;
                    r_drop      <= 1'b0;
                    r_emit      <= '0;
                    r_depth     <= '0;
                    r_have_prev <= 1'b0;
                    r_hvalid    <= '0;
                end else begin
                    r_emit <= r_emit + HW'(1);
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_no_start_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> !o_strobe)
        else $error("strobe right after accept");
    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scdh_pkg::ST_EMIT) |-> busy)
        else $error("emit while idle");
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_item.depth != '0))
        else $error("zero depth reported");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_item.last_result) |-> (r_state == scdh_pkg::ST_IDLE))
        else $error("last result while still busy");
    a_chain_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.insert |-> !w_gt[NCELL])
        else $error("event pushed off the chain tail");
`endif

endmodule
